// File: rtl/tpqc_pkg.sv
`timescale 1ns / 1ps

package tpqc_pkg;

	// Default frame limits.
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;

	// Field widths.
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned THR_W     = 8;
	localparam int unsigned CTR_W     = 10;
	localparam int unsigned BIN_W     = 11;
	localparam int unsigned QUAD_W    = 21;
	localparam int unsigned REG_IDX_W = 2;
	localparam int unsigned CFG_W     = 10;

	localparam logic [BIN_W-1:0]  BIN_MAX   = '1;
	localparam logic [QUAD_W-1:0] QUAD_MAX  = '1;
	localparam logic [THR_W-1:0]  THR_RESET = 8'd17;

	typedef enum logic [CMD_W-1:0] {
		CMD_FRAME_START = 3'd0,
		CMD_PIXEL       = 3'd1,
		CMD_ROW_END     = 3'd2,
		CMD_FRAME_END   = 3'd3,
		CMD_READ_COL    = 3'd4,
		CMD_READ_ROW    = 3'd5
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_CENTRE_COL = 2'd1,
		REG_CENTRE_ROW = 2'd2
	} reg_idx_t;

	// Control carried by the item in the read-modify-write stage.
	typedef struct packed {
		cmd_t cmd;
		logic write;     // pixel inside the frame: column bin is written back
		logic bright;    // pixel above threshold
		logic entry_ok;  // addressed entry has been written in this frame
	} s1_ctrl_t;

	function automatic logic [BIN_W-1:0] bin_sat_inc(input logic [BIN_W-1:0] v);
		return (v == BIN_MAX) ? v : v + BIN_W'(1);
	endfunction

	function automatic logic [QUAD_W-1:0] quad_sat_inc(input logic [QUAD_W-1:0] v);
		return (v == QUAD_MAX) ? v : v + QUAD_W'(1);
	endfunction

endpackage

// File: rtl/threshold_projection_quadrant_counter.sv
// Threshold projection and quadrant counter for a stream of camera items.
// Throughput: one item per cycle while in_stall is low; the column histogram memory is
// read at acceptance and written back from the read-modify-write stage, with a forwarding
// register for back-to-back bins. A result (frame report or bin read) leaves via the output register.
// Reset: arst_n is asynchronous and clears control, counters and configuration registers at once;
// the histogram memories are never swept: fill counts mask entries not written this frame.
`timescale 1ns / 1ps

module threshold_projection_quadrant_counter #(
	parameter int unsigned MAX_WIDTH  = tpqc_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = tpqc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port
	input  logic                           write_enable,
	input  logic [tpqc_pkg::REG_IDX_W-1:0] register_index,
	input  logic [tpqc_pkg::CFG_W-1:0]     write_data,
	// Input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tpqc_pkg::CMD_W-1:0]     command,
	input  logic [tpqc_pkg::PIX_W-1:0]     pixel_value,
	input  logic [tpqc_pkg::IDX_W-1:0]     bin_index,
	// Output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tpqc_pkg::BIN_W-1:0]     read_data,
	output logic [tpqc_pkg::QUAD_W-1:0]    quad_upper_left,
	output logic [tpqc_pkg::QUAD_W-1:0]    quad_upper_right,
	output logic [tpqc_pkg::QUAD_W-1:0]    quad_lower_left,
	output logic [tpqc_pkg::QUAD_W-1:0]    quad_lower_right,
	output logic [tpqc_pkg::QUAD_W-1:0]    bright_total,
	output logic                           is_frame_report
);

	// Position counters must be able to hold the maximum itself.
	localparam int unsigned CPW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RPW = $clog2(MAX_HEIGHT + 1);
	// Memory address widths.
	localparam int unsigned CAW = $clog2(MAX_WIDTH);
	localparam int unsigned RAW = $clog2(MAX_HEIGHT);
	// Common widths for comparing positions against 10-bit register and index values.
	localparam int unsigned CCW = (CPW > tpqc_pkg::IDX_W) ? CPW : tpqc_pkg::IDX_W;
	localparam int unsigned RCW = (RPW > tpqc_pkg::IDX_W) ? RPW : tpqc_pkg::IDX_W;
	localparam int unsigned SUM_W = tpqc_pkg::QUAD_W + 2;

	// Configuration registers.
	logic [tpqc_pkg::THR_W-1:0] thr_q;
	logic [tpqc_pkg::CTR_W-1:0] centre_col_q;
	logic [tpqc_pkg::CTR_W-1:0] centre_row_q;

	// Frame state held in flip-flops.
	logic [CPW-1:0]                col_pos_q;
	logic [CPW-1:0]                col_fill_q;  // columns 0..col_fill_q-1 written this frame
	logic [RPW-1:0]                row_pos_q;   // also the fill count of the row memory
	logic [tpqc_pkg::BIN_W-1:0]    accum_q;
	logic [tpqc_pkg::QUAD_W-1:0]   quad_q [4];

	// Histogram memories and their registered read data.
	logic [tpqc_pkg::BIN_W-1:0]    col_hist_q [MAX_WIDTH];
	logic [tpqc_pkg::BIN_W-1:0]    row_cnt_q  [MAX_HEIGHT];
	logic [tpqc_pkg::BIN_W-1:0]    col_rdata_q;
	logic [tpqc_pkg::BIN_W-1:0]    row_rdata_q;

	// Read-modify-write stage.
	logic                          valid_s1;
	tpqc_pkg::s1_ctrl_t            ctrl_s1;
	logic [CAW-1:0]                addr_s1;
	logic [tpqc_pkg::QUAD_W-1:0]   quad_s1 [4];

	// Last column bin written, for a read that was issued in the same cycle.
	logic                          fwd_valid_q;
	logic [CAW-1:0]                fwd_addr_q;
	logic [tpqc_pkg::BIN_W-1:0]    fwd_data_q;

	// Output register.
	logic                          out_valid_q;
	logic [tpqc_pkg::BIN_W-1:0]    read_data_q;
	logic [tpqc_pkg::QUAD_W-1:0]   quad_out_q [4];
	logic [tpqc_pkg::QUAD_W-1:0]   total_q;
	logic                          is_report_q;

	// Combinational signals.
	tpqc_pkg::cmd_t                cmd_in;
	logic                          in_accept;
	logic                          col_in_range;
	logic                          row_in_range;
	logic                          pix_ok;
	logic                          bright;
	logic [1:0]                    quad_sel;
	logic [CAW-1:0]                col_rd_addr;
	logic                          idx_col_ok;
	logic                          idx_row_ok;
	logic                          entry_ok;
	logic                          s1_result;
	logic                          s1_hold;
	logic                          fwd_hit;
	logic [tpqc_pkg::BIN_W-1:0]    col_old;
	logic [tpqc_pkg::BIN_W-1:0]    col_new;
	logic                          col_we;
	logic [SUM_W-1:0]              quad_sum;
	logic [tpqc_pkg::QUAD_W-1:0]   total;
	logic                          out_load;
	logic [tpqc_pkg::BIN_W-1:0]    read_value;

	assign cmd_in    = tpqc_pkg::cmd_t'(command);
	assign in_accept = in_valid && !in_stall;

	// The stage only holds when its result cannot move into a full, stalled output register.
	assign s1_result = valid_s1 && (ctrl_s1.cmd == tpqc_pkg::CMD_FRAME_END ||
		ctrl_s1.cmd == tpqc_pkg::CMD_READ_COL || ctrl_s1.cmd == tpqc_pkg::CMD_READ_ROW);
	assign s1_hold   = s1_result && out_valid_q && out_stall;
	assign in_stall  = s1_hold;

	// Decode at acceptance.
	assign col_in_range = col_pos_q < CPW'(MAX_WIDTH);
	assign row_in_range = row_pos_q < RPW'(MAX_HEIGHT);
	assign pix_ok       = col_in_range && row_in_range;
	assign bright       = pixel_value > thr_q;
	// Bit 0 selects the right half, bit 1 the lower half.
	assign quad_sel[0]  = CCW'(col_pos_q) >= CCW'(centre_col_q);
	assign quad_sel[1]  = RCW'(row_pos_q) >= RCW'(centre_row_q);
	assign col_rd_addr  = (cmd_in == tpqc_pkg::CMD_PIXEL) ? CAW'(col_pos_q) : CAW'(bin_index);
	// Column positions only ever advance by one from zero within a row, so every
	// column below the fill count has been written since frame start.
	assign idx_col_ok   = CCW'(bin_index) < CCW'(col_fill_q);
	assign idx_row_ok   = RCW'(bin_index) < RCW'(row_pos_q);

	always_comb begin
		case (cmd_in)
			tpqc_pkg::CMD_PIXEL:    entry_ok = col_pos_q < col_fill_q;
			tpqc_pkg::CMD_READ_COL: entry_ok = idx_col_ok;
			tpqc_pkg::CMD_READ_ROW: entry_ok = idx_row_ok;
			default:                entry_ok = 1'b0;
		endcase
	end

	// Read-modify-write of the column bin. An entry not yet written this frame reads
	// as zero; a bin written back in the cycle of this item's read is forwarded.
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign col_old = !ctrl_s1.entry_ok ? '0 : (fwd_hit ? fwd_data_q : col_rdata_q);
	assign col_new = ctrl_s1.bright ? tpqc_pkg::bin_sat_inc(col_old) : col_old;
	// Every in-frame pixel writes its bin, bright or not, to keep the fill count exact.
	assign col_we  = valid_s1 && ctrl_s1.write;

	// Frame report total, saturated to the counter width.
	assign quad_sum = SUM_W'(quad_s1[0]) + SUM_W'(quad_s1[1]) +
		SUM_W'(quad_s1[2]) + SUM_W'(quad_s1[3]);
	assign total    = (quad_sum > SUM_W'(tpqc_pkg::QUAD_MAX)) ? tpqc_pkg::QUAD_MAX :
		quad_sum[tpqc_pkg::QUAD_W-1:0];

	always_comb begin
		case (ctrl_s1.cmd)
			tpqc_pkg::CMD_READ_COL: read_value = col_old;
			tpqc_pkg::CMD_READ_ROW: read_value = ctrl_s1.entry_ok ? row_rdata_q : '0;
			default:                read_value = '0;
		endcase
	end

	assign out_load = s1_result && (!out_valid_q || !out_stall);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= tpqc_pkg::THR_RESET;
			centre_col_q <= '0;
			centre_row_q <= '0;
		end else if (write_enable) begin
			case (tpqc_pkg::reg_idx_t'(register_index))
				tpqc_pkg::REG_THRESHOLD:  thr_q        <= write_data[tpqc_pkg::THR_W-1:0];
				tpqc_pkg::REG_CENTRE_COL: centre_col_q <= write_data[tpqc_pkg::CTR_W-1:0];
				tpqc_pkg::REG_CENTRE_ROW: centre_row_q <= write_data[tpqc_pkg::CTR_W-1:0];
				default: ;
			endcase
		end
	end

	// Positions, row accumulator, fill count and quadrant counters update at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			col_fill_q <= '0;
			row_pos_q  <= '0;
			accum_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				quad_q[i] <= '0;
			end
		end else if (in_accept) begin
			case (cmd_in)
				tpqc_pkg::CMD_FRAME_START: begin
					col_pos_q  <= '0;
					col_fill_q <= '0;
					row_pos_q  <= '0;
					accum_q    <= '0;
					for (int i = 0; i < 4; i++) begin
						quad_q[i] <= '0;
					end
				end
				tpqc_pkg::CMD_PIXEL: begin
					if (pix_ok && bright) begin
						accum_q          <= tpqc_pkg::bin_sat_inc(accum_q);
						quad_q[quad_sel] <= tpqc_pkg::quad_sat_inc(quad_q[quad_sel]);
					end
					if (col_in_range) begin
						col_pos_q <= col_pos_q + CPW'(1);
					end
					if (pix_ok && col_pos_q == col_fill_q) begin
						col_fill_q <= col_fill_q + CPW'(1);
					end
				end
				tpqc_pkg::CMD_ROW_END: begin
					if (row_in_range) begin
						row_pos_q <= row_pos_q + RPW'(1);
					end
					col_pos_q <= '0;
					accum_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// Column histogram memory: read at acceptance, written back from the stage.
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_hist_q[addr_s1] <= col_new;
		end
		if (in_accept) begin
			col_rdata_q <= col_hist_q[col_rd_addr];
		end
	end

	// Row count memory: written at row end with the finished row's count.
	always_ff @(posedge clk) begin
		if (in_accept && cmd_in == tpqc_pkg::CMD_ROW_END && row_in_range) begin
			row_cnt_q[RAW'(row_pos_q)] <= accum_q;
		end
		if (in_accept) begin
			row_rdata_q <= row_cnt_q[RAW'(bin_index)];
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s1_hold) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ctrl_s1.cmd      <= cmd_in;
			ctrl_s1.write    <= (cmd_in == tpqc_pkg::CMD_PIXEL) && pix_ok;
			ctrl_s1.bright   <= bright;
			ctrl_s1.entry_ok <= entry_ok;
			addr_s1          <= col_rd_addr;
			// Snapshot of the counters as they stand when the frame end is taken.
			for (int i = 0; i < 4; i++) begin
				quad_s1[i] <= quad_q[i];
			end
		end
	end

	// The forwarding register follows the stage: it is refreshed whenever the stage
	// takes a new item and dropped when the stage empties, so it always pairs the
	// item in the stage with the write made in the cycle of that item's read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (in_accept) begin
			fwd_valid_q <= col_we;
		end else if (!s1_hold) begin
			fwd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= col_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_report_q <= (ctrl_s1.cmd == tpqc_pkg::CMD_FRAME_END);
			read_data_q <= read_value;
			if (ctrl_s1.cmd == tpqc_pkg::CMD_FRAME_END) begin
				for (int i = 0; i < 4; i++) begin
					quad_out_q[i] <= quad_s1[i];
				end
				total_q <= total;
			end else begin
				for (int i = 0; i < 4; i++) begin
					quad_out_q[i] <= '0;
				end
				total_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = read_data_q;
	assign quad_upper_left  = quad_out_q[0];
	assign quad_upper_right = quad_out_q[1];
	assign quad_lower_left  = quad_out_q[2];
	assign quad_lower_right = quad_out_q[3];
	assign bright_total     = total_q;
	assign is_frame_report  = is_report_q;

`ifndef SYNTHESIS
	// Input is only held back when a result is stuck behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked output");

	// Fill counts never run past the memory depths.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(col_fill_q <= CPW'(MAX_WIDTH)) && (row_pos_q <= RPW'(MAX_HEIGHT)))
		else $error("fill count beyond memory depth");

	// An in-frame pixel never skips past the written region of the column memory.
	a_fill_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd_in == tpqc_pkg::CMD_PIXEL && pix_ok) |-> (col_pos_q <= col_fill_q))
		else $error("column written beyond fill count");

	// Frame start clears the fill counts, positions and row accumulator.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd_in == tpqc_pkg::CMD_FRAME_START) |=>
		(col_fill_q == '0 && row_pos_q == '0 && accum_q == '0 && col_pos_q == '0))
		else $error("frame start did not clear the frame state");
`endif

endmodule
